### hw/rtl/lcs_pkg.sv
`timescale 1ns / 1ps

package lcs_pkg;

	// fixed field widths
	localparam int LEN_W = 11;
	localparam int SYM_W = 8;
	localparam int OUT_W = 11;

	// result saturates at the largest 11-bit value
	localparam logic [OUT_W-1:0] OUT_MAX = 11'd2047;

	// configuration register indexes
	localparam logic REG_FIRST_LENGTH  = 1'b0;
	localparam logic REG_SECOND_LENGTH = 1'b1;

	// reset value of both length registers
	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

	// sequencer states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROW,
		ST_CELL
	} state_t;

endpackage

### hw/rtl/lcs_ram.sv
`timescale 1ns / 1ps

module lcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/lcs_length_engine.sv
`timescale 1ns / 1ps

// channel  direction  handshake                 payload
// item     in         item_valid / item_stall   which_sequence, symbol
// result   out        result_valid / result_stall  lcs_length
// cfg      in         cfg_we                    cfg_index, cfg_data
//
// symbols load one per cycle, when not stalled, into the two sequence memories.
// the transaction that completes both sequences starts the sweep: one table
// cell per cycle on a shared compare/max unit, the final cell waiting while
// a result is still stalled, and a row state fetches each row's symbol.
// item_stall is high for the whole sweep; the score row is never cleared,
// its first row reads as zero. reset is asynchronous and clears control only.

module lcs_length_engine #(
	parameter int MAX_LEN = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [lcs_pkg::LEN_W-1:0] cfg_data,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic                      which_sequence,
	input  logic [lcs_pkg::SYM_W-1:0] symbol,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [lcs_pkg::OUT_W-1:0] lcs_length
);

	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int AW    = $clog2(MAX_LEN);
	localparam int EW    = (CNT_W > lcs_pkg::LEN_W) ? CNT_W : lcs_pkg::LEN_W;

	lcs_pkg::state_t state_q, state_d;

	logic [lcs_pkg::LEN_W-1:0] first_length_q, second_length_q;
	logic [CNT_W-1:0]          first_count_q, second_count_q;
	logic [CNT_W-1:0]          row_q, col_q;
	logic [CNT_W-1:0]          diag_q, left_q;
	logic                      result_valid_q;
	logic [lcs_pkg::OUT_W-1:0] lcs_length_q;

	logic [EW-1:0]    len1_x, len2_x;
	logic [CNT_W-1:0] len1, len2;
	logic             accept, first_take, second_take, complete;
	logic [CNT_W-1:0] first_count_nx, second_count_nx;

	logic [lcs_pkg::SYM_W-1:0] first_rdata, second_rdata;
	logic [CNT_W-1:0]          score_rdata;
	logic [CNT_W-1:0]          up, cell_v, col_m1, row_m1;
	logic                      last_col, last_row, final_cell, cell_go, match;
	logic [EW-1:0]             cell_v_x;
	logic [lcs_pkg::OUT_W-1:0] cell_sat;

	logic          first_re, score_re, second_re, score_we;
	logic [AW-1:0] first_raddr, score_raddr, score_waddr, second_raddr;

	// effective lengths: zero counts as one, above MAX_LEN clamps
	always_comb begin
		len1_x = EW'(first_length_q);
		len2_x = EW'(second_length_q);
		if (len1_x == '0) begin
			len1 = CNT_W'(1);
		end else if (len1_x > EW'(MAX_LEN)) begin
			len1 = CNT_W'(MAX_LEN);
		end else begin
			len1 = len1_x[CNT_W-1:0];
		end
		if (len2_x == '0) begin
			len2 = CNT_W'(1);
		end else if (len2_x > EW'(MAX_LEN)) begin
			len2 = CNT_W'(MAX_LEN);
		end else begin
			len2 = len2_x[CNT_W-1:0];
		end
	end

	// load path and completion check
	assign accept          = item_valid && !item_stall;
	assign first_take      = accept && !which_sequence && (first_count_q < len1);
	assign second_take     = accept && which_sequence && (second_count_q < len2);
	assign first_count_nx  = first_count_q + CNT_W'(first_take);
	assign second_count_nx = second_count_q + CNT_W'(second_take);
	assign complete        = accept && (first_count_nx >= len1) && (second_count_nx >= len2);

	// cell unit: match adds one to diagonal, else larger of up and left
	assign up       = (row_q == CNT_W'(1)) ? '0 : score_rdata;
	assign match    = (first_rdata == second_rdata);
	assign cell_v   = match ? (diag_q + CNT_W'(1)) : ((up > left_q) ? up : left_q);
	assign last_col = (col_q == len1);
	assign last_row = (row_q == len2);
	assign col_m1   = col_q - CNT_W'(1);
	assign row_m1   = row_q - CNT_W'(1);

	// final cell waits while the previous result is still pending
	assign final_cell = (state_q == lcs_pkg::ST_CELL) && last_col && last_row;
	assign cell_go    = (state_q == lcs_pkg::ST_CELL)
		&& !(final_cell && result_valid_q && result_stall);

	// saturate result to the output width
	assign cell_v_x = EW'(cell_v);
	assign cell_sat = (cell_v_x > EW'(lcs_pkg::OUT_MAX)) ? lcs_pkg::OUT_MAX
		: cell_v_x[lcs_pkg::OUT_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lcs_pkg::ST_LOAD: begin
				if (complete) begin
					state_d = lcs_pkg::ST_ROW;
				end
			end
			lcs_pkg::ST_ROW: begin
				state_d = lcs_pkg::ST_CELL;
			end
			lcs_pkg::ST_CELL: begin
				if (cell_go && last_col) begin
					state_d = last_row ? lcs_pkg::ST_LOAD : lcs_pkg::ST_ROW;
				end
			end
			default: begin
				state_d = lcs_pkg::ST_LOAD;
			end
		endcase
	end

	// state outputs: stall and memory ports
	always_comb begin
		item_stall   = 1'b1;
		first_re     = 1'b0;
		score_re     = 1'b0;
		second_re    = 1'b0;
		first_raddr  = col_q[AW-1:0];
		score_raddr  = col_q[AW-1:0];
		second_raddr = row_m1[AW-1:0];
		score_we     = 1'b0;
		score_waddr  = col_m1[AW-1:0];
		case (state_q)
			lcs_pkg::ST_LOAD: begin
				item_stall = 1'b0;
			end
			lcs_pkg::ST_ROW: begin
				first_re    = 1'b1;
				score_re    = 1'b1;
				second_re   = 1'b1;
				first_raddr = '0;
				score_raddr = '0;
			end
			lcs_pkg::ST_CELL: begin
				first_re = cell_go && !last_col;
				score_re = cell_go && !last_col;
				score_we = cell_go;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_length_q  <= lcs_pkg::LEN_RESET;
			second_length_q <= lcs_pkg::LEN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == lcs_pkg::REG_FIRST_LENGTH) begin
				first_length_q <= cfg_data;
			end
			if (cfg_index == lcs_pkg::REG_SECOND_LENGTH) begin
				second_length_q <= cfg_data;
			end
		end
	end

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lcs_pkg::ST_LOAD;
			first_count_q  <= '0;
			second_count_q <= '0;
			row_q          <= '0;
			col_q          <= '0;
			diag_q         <= '0;
			left_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (complete) begin
				first_count_q  <= '0;
				second_count_q <= '0;
				row_q          <= CNT_W'(1);
			end else begin
				first_count_q  <= first_count_nx;
				second_count_q <= second_count_nx;
				if (cell_go && last_col && !last_row) begin
					row_q <= row_q + CNT_W'(1);
				end
			end
			if (state_q == lcs_pkg::ST_ROW) begin
				col_q  <= CNT_W'(1);
				diag_q <= '0;
				left_q <= '0;
			end else if (cell_go) begin
				col_q  <= col_q + CNT_W'(1);
				diag_q <= up;
				left_q <= cell_v;
			end
			if (final_cell && cell_go) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (final_cell && cell_go) begin
			lcs_length_q <= cell_sat;
		end
	end

	assign result_valid = result_valid_q;
	assign lcs_length   = lcs_length_q;

	// first sequence symbols
	lcs_ram #(
		.WIDTH(lcs_pkg::SYM_W),
		.DEPTH(MAX_LEN)
	) u_first_ram (
		.clk  (clk),
		.we   (first_take),
		.waddr(first_count_q[AW-1:0]),
		.wdata(symbol),
		.re   (first_re),
		.raddr(first_raddr),
		.rdata(first_rdata)
	);

	// second sequence symbols
	lcs_ram #(
		.WIDTH(lcs_pkg::SYM_W),
		.DEPTH(MAX_LEN)
	) u_second_ram (
		.clk  (clk),
		.we   (second_take),
		.waddr(second_count_q[AW-1:0]),
		.wdata(symbol),
		.re   (second_re),
		.raddr(second_raddr),
		.rdata(second_rdata)
	);

	// score row, entry k holds column k+1
	lcs_ram #(
		.WIDTH(CNT_W),
		.DEPTH(MAX_LEN)
	) u_score_ram (
		.clk  (clk),
		.we   (score_we),
		.waddr(score_waddr),
		.wdata(cell_v),
		.re   (score_re),
		.raddr(score_raddr),
		.rdata(score_rdata)
	);

endmodule
